// File: design/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// shared types and constants for the sphere containment and contact pipeline
// ----------------------------------------------------------------------------
package sic_pkg;

    localparam int FRAC_BITS = 16;

    localparam int POS_W = 32;              // signed position / centre width
    localparam int RAD_W = 31;              // unsigned radius width
    localparam int D_W   = POS_W + 1;       // offset from centre, and its magnitude
    localparam int SQ_W  = 2 * D_W;         // one squared offset
    localparam int S_W   = 66;              // sum of three squares, below 3 * 2^64
    localparam int R2_W  = 64;              // squared radius terms
    localparam int N_W   = S_W / 2;         // integer square root of the sum
    localparam int REM_W = N_W + 3;         // square root partial remainder
    localparam int NR_W  = N_W + 1;         // signed n - R
    localparam int Q_W   = N_W;             // push quotient, below 2^33
    localparam int P_W   = D_W + Q_W;       // |d| * |n - R|

    localparam int SQ_STEPS  = N_W;         // one root bit per stage
    localparam int DIV_STEPS = Q_W;         // one quotient bit per stage

    localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(64'd1 << FRAC_BITS);

    typedef enum logic [1:0] {
        CFG_CENTER_X      = 2'd0,
        CFG_CENTER_Y      = 2'd1,
        CFG_CENTER_Z      = 2'd2,
        CFG_SPHERE_RADIUS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic        [RAD_W-1:0] probe_radius;
    } t_sic_in;

    typedef struct packed {
        logic                    point_inside;
        logic                    body_inside;
        logic                    touching;
        logic signed [POS_W-1:0] push_x;
        logic signed [POS_W-1:0] push_y;
        logic signed [POS_W-1:0] push_z;
    } t_sic_out;

    typedef struct packed {
        logic point_inside;
        logic body_inside;
        logic touching;
    } t_sic_flags;

    // saturate the magnitude, then negate it unless the product d * (n - R) was negative
    function automatic logic [POS_W-1:0] push_sat(input logic [Q_W-1:0] q,
                                                  input logic neg_prod);
        logic [Q_W-1:0] m;
        logic [Q_W-1:0] neg_v;
        begin
            if (neg_prod) begin
                m = (q > Q_W'(33'h0_7FFF_FFFF)) ? Q_W'(33'h0_7FFF_FFFF) : q;
                push_sat = m[POS_W-1:0];
            end else begin
                m = (q > Q_W'(33'h0_8000_0000)) ? Q_W'(33'h0_8000_0000) : q;
                neg_v = Q_W'(0) - m;
                push_sat = neg_v[POS_W-1:0];
            end
        end
    endfunction

endpackage

// File: design/sphere_inside_and_contact.sv
// throughput: one transaction per cycle unless a held result stalls the pipe; the 33 square
//   root stages and 33 divider stages set the depth, every stage moves together on a common enable
// a held result with i_out_stall high freezes the whole pipe and raises o_in_stall
// reset (synchronous, active low) clears all valid bits and loads the centre to zero
//   and the sphere radius to 1.0; configuration writes are always taken
// ----------------------------------------------------------------------------
// sphere_inside_and_contact
// pipelined point / body containment, shell contact test and contact push
// ----------------------------------------------------------------------------
module sphere_inside_and_contact
    import sic_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input transactions
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_sic_in             i_in_data,
    // result transactions
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_sic_out            o_out_data,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  t_cfg_idx            i_cfg_index,
    input  logic [POS_W-1:0]    i_cfg_data
);

    // stage positions in the valid shift line
    localparam int PRE_N   = 5;
    localparam int SQ0     = PRE_N;
    localparam int Q1_IDX  = SQ0 + SQ_STEPS;
    localparam int DV0     = Q1_IDX + 3;
    localparam int OUT_IDX = DV0 + DIV_STEPS;
    localparam int N_STG   = OUT_IDX + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] r_cx, r_cy, r_cz;
    logic        [RAD_W-1:0] r_rad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= RADIUS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:      r_cx  <= i_cfg_data;
                CFG_CENTER_Y:      r_cy  <= i_cfg_data;
                CFG_CENTER_Z:      r_cz  <= i_cfg_data;
                CFG_SPHERE_RADIUS: r_rad <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: one enable for every stage, the output register
    // holds while the downstream side stalls
    // ------------------------------------------------------------------
    logic [N_STG-1:0] r_vld;
    logic             en;

    assign en          = !(r_vld[OUT_IDX] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[OUT_IDX];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[N_STG-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: offsets from the centre
    // ------------------------------------------------------------------
    logic signed [D_W-1:0]   r1_d [3];
    logic        [RAD_W-1:0] r1_rb, r1_rp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d[0] <= {i_in_data.pos_x[POS_W-1], i_in_data.pos_x} - {r_cx[POS_W-1], r_cx};
            r1_d[1] <= {i_in_data.pos_y[POS_W-1], i_in_data.pos_y} - {r_cy[POS_W-1], r_cy};
            r1_d[2] <= {i_in_data.pos_z[POS_W-1], i_in_data.pos_z} - {r_cz[POS_W-1], r_cz};
            r1_rb   <= r_rad;
            r1_rp   <= i_in_data.probe_radius;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: magnitudes and signs, shell radii R + r and |R - r|
    // ------------------------------------------------------------------
    logic [D_W-1:0]   r2_mag [3];
    logic [2:0]       r2_sd;
    logic [RAD_W-1:0] r2_rb;
    logic [RAD_W:0]   r2_rsum, r2_rdif;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_mag[i] <= r1_d[i][D_W-1] ? D_W'(-r1_d[i]) : D_W'(r1_d[i]);
                r2_sd[i]  <= r1_d[i][D_W-1];
            end
            r2_rb   <= r1_rb;
            r2_rsum <= {1'b0, r1_rb} + {1'b0, r1_rp};
            r2_rdif <= (r1_rb >= r1_rp) ? {1'b0, r1_rb - r1_rp} : {1'b0, r1_rp - r1_rb};
        end
    end

    // ------------------------------------------------------------------
    // stage 3: squares
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]  r3_sq [3];
    logic [R2_W-1:0]  r3_rr, r3_lo2, r3_hi2;
    logic [D_W-1:0]   r3_mag [3];
    logic [2:0]       r3_sd;
    logic [RAD_W-1:0] r3_rb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= r2_mag[i] * r2_mag[i];
            end
            r3_rr  <= R2_W'(r2_rb) * R2_W'(r2_rb);
            r3_lo2 <= R2_W'(r2_rdif) * R2_W'(r2_rdif);
            r3_hi2 <= R2_W'(r2_rsum) * R2_W'(r2_rsum);
            r3_mag <= r2_mag;
            r3_sd  <= r2_sd;
            r3_rb  <= r2_rb;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: squared distance
    // ------------------------------------------------------------------
    logic [S_W-1:0]   r4_s;
    logic [R2_W-1:0]  r4_rr, r4_lo2, r4_hi2;
    logic [D_W-1:0]   r4_mag [3];
    logic [2:0]       r4_sd;
    logic [RAD_W-1:0] r4_rb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_s   <= S_W'(r3_sq[0]) + S_W'(r3_sq[1]) + S_W'(r3_sq[2]);
            r4_rr  <= r3_rr;
            r4_lo2 <= r3_lo2;
            r4_hi2 <= r3_hi2;
            r4_mag <= r3_mag;
            r4_sd  <= r3_sd;
            r4_rb  <= r3_rb;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: containment and shell band flags, all exact
    // ------------------------------------------------------------------
    logic [S_W-1:0]   r5_s;
    t_sic_flags       r5_flg;
    logic [D_W-1:0]   r5_mag [3];
    logic [2:0]       r5_sd;
    logic [RAD_W-1:0] r5_rb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_s                <= r4_s;
            r5_flg.point_inside <= (r4_s <= S_W'(r4_rr));
            r5_flg.body_inside  <= (r4_s <= S_W'(r4_lo2));
            r5_flg.touching     <= (r4_s >= S_W'(r4_lo2)) && (r4_s <= S_W'(r4_hi2));
            r5_mag              <= r4_mag;
            r5_sd               <= r4_sd;
            r5_rb               <= r4_rb;
        end
    end

    // ------------------------------------------------------------------
    // integer square root, restoring, one root bit per stage
    // ------------------------------------------------------------------
    logic [S_W-1:0]   r_sq_s    [SQ_STEPS];
    logic [N_W-1:0]   r_sq_root [SQ_STEPS];
    logic [REM_W-1:0] r_sq_rem  [SQ_STEPS];
    t_sic_flags       r_sq_flg  [SQ_STEPS];
    logic [D_W-1:0]   r_sq_mag  [SQ_STEPS][3];
    logic [2:0]       r_sq_sd   [SQ_STEPS];
    logic [RAD_W-1:0] r_sq_rb   [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [S_W-1:0]   s_in;
        logic [N_W-1:0]   root_in;
        logic [REM_W-1:0] rem_in;
        t_sic_flags       flg_in;
        logic [D_W-1:0]   mag_in [3];
        logic [2:0]       sd_in;
        logic [RAD_W-1:0] rb_in;
        logic [REM_W+1:0] rem_sh, trial;

        if (k == 0) begin : g_first
            always_comb begin
                s_in    = r5_s;
                root_in = '0;
                rem_in  = '0;
                flg_in  = r5_flg;
                mag_in  = r5_mag;
                sd_in   = r5_sd;
                rb_in   = r5_rb;
            end
        end else begin : g_next
            always_comb begin
                s_in    = r_sq_s[k-1];
                root_in = r_sq_root[k-1];
                rem_in  = r_sq_rem[k-1];
                flg_in  = r_sq_flg[k-1];
                mag_in  = r_sq_mag[k-1];
                sd_in   = r_sq_sd[k-1];
                rb_in   = r_sq_rb[k-1];
            end
        end

        assign rem_sh = {rem_in, s_in[S_W-1 -: 2]};
        assign trial  = (REM_W+2)'({root_in, 2'b01});

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (rem_sh >= trial) begin
                    r_sq_rem[k]  <= REM_W'(rem_sh - trial);
                    r_sq_root[k] <= {root_in[N_W-2:0], 1'b1};
                end else begin
                    r_sq_rem[k]  <= REM_W'(rem_sh);
                    r_sq_root[k] <= {root_in[N_W-2:0], 1'b0};
                end
                r_sq_s[k]   <= {s_in[S_W-3:0], 2'b00};
                r_sq_flg[k] <= flg_in;
                r_sq_mag[k] <= mag_in;
                r_sq_sd[k]  <= sd_in;
                r_sq_rb[k]  <= rb_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // n - R, its magnitude, then |d_i| * |n - R|
    // ------------------------------------------------------------------
    logic signed [NR_W-1:0] rq1_nr;
    logic [N_W-1:0]         rq1_n;
    t_sic_flags             rq1_flg;
    logic [D_W-1:0]         rq1_mag [3];
    logic [2:0]             rq1_sd;

    logic [Q_W-1:0]         rq2_nrm;
    logic                   rq2_snr;
    logic                   rq2_zero;
    logic [N_W-1:0]         rq2_n;
    t_sic_flags             rq2_flg;
    logic [D_W-1:0]         rq2_mag [3];
    logic [2:0]             rq2_sd;

    logic [P_W-1:0]         rq3_prod [3];
    logic [2:0]             rq3_sgn;
    logic                   rq3_zero;
    logic [N_W-1:0]         rq3_n;
    t_sic_flags             rq3_flg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // q1
            rq1_nr  <= signed'({1'b0, r_sq_root[SQ_STEPS-1]})
                     - signed'(NR_W'(r_sq_rb[SQ_STEPS-1]));
            rq1_n   <= r_sq_root[SQ_STEPS-1];
            rq1_flg <= r_sq_flg[SQ_STEPS-1];
            rq1_mag <= r_sq_mag[SQ_STEPS-1];
            rq1_sd  <= r_sq_sd[SQ_STEPS-1];
            // q2: zero distance or no contact gives no push
            rq2_nrm  <= rq1_nr[NR_W-1] ? Q_W'(-rq1_nr) : Q_W'(rq1_nr);
            rq2_snr  <= rq1_nr[NR_W-1];
            rq2_zero <= !rq1_flg.touching || (rq1_n == '0);
            rq2_n    <= rq1_n;
            rq2_flg  <= rq1_flg;
            rq2_mag  <= rq1_mag;
            rq2_sd   <= rq1_sd;
            // q3
            for (int i = 0; i < 3; i++) begin
                rq3_prod[i] <= rq2_mag[i] * rq2_nrm;
                rq3_sgn[i]  <= rq2_sd[i] ^ rq2_snr;
            end
            rq3_zero <= rq2_zero;
            rq3_n    <= rq2_n;
            rq3_flg  <= rq2_flg;
        end
    end

    // ------------------------------------------------------------------
    // restoring divide by n, one quotient bit per stage for all three axes;
    // the quotient bits replace the low dividend bits as they shift out
    // ------------------------------------------------------------------
    logic [Q_W-1:0] r_dv_rem [DIV_STEPS][3];
    logic [Q_W-1:0] r_dv_qb  [DIV_STEPS][3];
    logic [N_W-1:0] r_dv_n   [DIV_STEPS];
    logic [2:0]     r_dv_sgn [DIV_STEPS];
    logic           r_dv_zero[DIV_STEPS];
    t_sic_flags     r_dv_flg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [Q_W-1:0] rem_in [3];
        logic [Q_W-1:0] qb_in  [3];
        logic [N_W-1:0] n_in;
        logic [2:0]     sgn_in;
        logic           zero_in;
        t_sic_flags     flg_in;
        logic [Q_W:0]   rem_sh [3];

        if (k == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = rq3_prod[i][P_W-1:Q_W];
                    qb_in[i]  = rq3_prod[i][Q_W-1:0];
                end
                n_in    = rq3_n;
                sgn_in  = rq3_sgn;
                zero_in = rq3_zero;
                flg_in  = rq3_flg;
            end
        end else begin : g_next
            always_comb begin
                rem_in  = r_dv_rem[k-1];
                qb_in   = r_dv_qb[k-1];
                n_in    = r_dv_n[k-1];
                sgn_in  = r_dv_sgn[k-1];
                zero_in = r_dv_zero[k-1];
                flg_in  = r_dv_flg[k-1];
            end
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rem_sh[i] = {rem_in[i], qb_in[i][Q_W-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (rem_sh[i] >= {1'b0, n_in}) begin
                        r_dv_rem[k][i] <= Q_W'(rem_sh[i] - {1'b0, n_in});
                        r_dv_qb[k][i]  <= {qb_in[i][Q_W-2:0], 1'b1};
                    end else begin
                        r_dv_rem[k][i] <= Q_W'(rem_sh[i]);
                        r_dv_qb[k][i]  <= {qb_in[i][Q_W-2:0], 1'b0};
                    end
                end
                r_dv_n[k]    <= n_in;
                r_dv_sgn[k]  <= sgn_in;
                r_dv_zero[k] <= zero_in;
                r_dv_flg[k]  <= flg_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register: sign, saturation and the no-push case
    // ------------------------------------------------------------------
    t_sic_out   r_out;
    t_sic_flags lst_flg;
    logic       lst_zero;

    assign lst_flg  = r_dv_flg[DIV_STEPS-1];
    assign lst_zero = r_dv_zero[DIV_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.point_inside <= lst_flg.point_inside;
            r_out.body_inside  <= lst_flg.body_inside;
            r_out.touching     <= lst_flg.touching;
            if (lst_zero) begin
                r_out.push_x <= '0;
                r_out.push_y <= '0;
                r_out.push_z <= '0;
            end else begin
                r_out.push_x <= push_sat(r_dv_qb[DIV_STEPS-1][0], r_dv_sgn[DIV_STEPS-1][0]);
                r_out.push_y <= push_sat(r_dv_qb[DIV_STEPS-1][1], r_dv_sgn[DIV_STEPS-1][1]);
                r_out.push_z <= push_sat(r_dv_qb[DIV_STEPS-1][2], r_dv_sgn[DIV_STEPS-1][2]);
            end
        end
    end

    assign o_out_data = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // no contact means no push
    a_no_touch_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.touching) |->
        (o_out_data.push_x == '0 && o_out_data.push_y == '0 && o_out_data.push_z == '0))
        else $error("push without contact");

    // the input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // a transaction in the last divider stage reaches the output when the pipe moves
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[OUT_IDX-1] && en) |=> o_out_valid)
        else $error("transaction lost before the output register");

endmodule

// File: tb/sphere_inside_and_contact_tb.sv
// ----------------------------------------------------------------------------
// sphere_inside_and_contact_tb
// self-checking bench: a directed table then random particles over several
// sphere settings, every result compared with a typed-in expectation or a bit-exact predictor
// ----------------------------------------------------------------------------
module sphere_inside_and_contact_tb;
    import sic_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_WAIT  = 100;      // longer than an unstalled pass through the pipe
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 150;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind  kind;
        t_cfg_idx   idx;
        logic [31:0] wdata;
        t_sic_in    item;
        bit         has_exp;
        t_sic_out   exp;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_sic_in    i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_sic_out   o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index = CFG_CENTER_X;
    logic [31:0] i_cfg_data = '0;

    // bench copy of the sphere registers
    logic signed [31:0] sph_cx = '0, sph_cy = '0, sph_cz = '0;
    logic        [30:0] sph_rad = RADIUS_RST;

    t_sic_out   contact_q[$];       // expected results, oldest first
    bit         row_has_exp = 0;    // typed-in expectation rides with the item
    t_sic_out   row_exp;
    int         mismatches = 0;
    int         cycles = 0;

    sphere_inside_and_contact dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] abs64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // one push component: -(d * (n - R)) / n, magnitude truncated, then saturated
    function automatic logic [31:0] push_axis(longint di, longint nr, logic [63:0] n);
        logic [127:0] q;
        bit           differ, neg_prod, neg;
        logic [127:0] lim, m;
        begin
            differ   = (di < 0) != (nr < 0);
            q        = (128'(abs64(di)) * 128'(abs64(nr))) / 128'(n);
            neg_prod = differ && q[127:64] == 0 && q != 0;
            neg      = !neg_prod && q != 0;
            lim      = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            m        = (q > lim) ? lim : q;
            if (q[127:64] != 0 && differ) begin
                neg = 0;
                m   = 128'h7FFF_FFFF;
            end
            return neg ? 32'(-m) : 32'(m);
        end
    endfunction

    // containment flags and contact push for one particle
    function automatic t_sic_out sphere_contact(t_sic_in it);
        longint       d[3];
        longint       rad, prad, nr;
        logic [127:0] s, rr, lo2, hi2, c;
        logic [63:0]  n;
        t_sic_out     res;
        begin
            d[0] = longint'(it.pos_x) - longint'(sph_cx);
            d[1] = longint'(it.pos_y) - longint'(sph_cy);
            d[2] = longint'(it.pos_z) - longint'(sph_cz);
            s = '0;
            for (int i = 0; i < 3; i++) s += 128'(abs64(d[i])) * 128'(abs64(d[i]));
            rad  = longint'({33'b0, sph_rad});
            prad = longint'({33'b0, it.probe_radius});
            rr   = 128'(rad) * 128'(rad);
            lo2  = 128'(abs64(rad - prad)) * 128'(abs64(rad - prad));
            hi2  = 128'(rad + prad) * 128'(rad + prad);
            res  = '0;
            res.point_inside = (s <= rr);
            res.body_inside  = (s <= lo2);
            res.touching     = (s >= lo2) && (s <= hi2);
            if (res.touching) begin
                n = '0;
                for (int b = 34; b >= 0; b--) begin
                    c = 128'(n | (64'd1 << b));
                    if (c * c <= s) n = 64'(c);
                end
                if (n != 0) begin
                    nr = longint'(n) - rad;
                    res.push_x = push_axis(d[0], nr, n);
                    res.push_y = push_axis(d[1], nr, n);
                    res.push_z = push_axis(d[2], nr, n);
                end
            end
            return res;
        end
    endfunction

    // input side: record the expectation of every accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            contact_q.push_back(row_has_exp ? row_exp : sphere_contact(i_in_data));
        end
    end

    // output side: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_sic_out exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (contact_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                exp = contact_q.pop_front();
                if (o_out_data.point_inside !== exp.point_inside ||
                    o_out_data.body_inside  !== exp.body_inside  ||
                    o_out_data.touching     !== exp.touching     ||
                    o_out_data.push_x       !== exp.push_x       ||
                    o_out_data.push_y       !== exp.push_y       ||
                    o_out_data.push_z       !== exp.push_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", exp, o_out_data);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall: short bursts, the odd long one, clean stretches,
    // and one long hold-off while particles are on offer so the pipe fills
    // and stalls its input
    initial begin
        int  run_len;
        bit  held;
        held = 0;
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 25);
            repeat (run_len) @(negedge i_clk) i_out_stall <= 1'b0;
            if (!held && cycles > 2000 && i_in_valid) begin
                held = 1;
                repeat (400) @(negedge i_clk) i_out_stall <= 1'b1;
            end else begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(1, 3);
                repeat (run_len) @(negedge i_clk) i_out_stall <= 1'b1;
            end
        end
    end

    // register write, only once the pipe has drained
    task automatic write_reg(t_cfg_idx idx, logic [31:0] wdata);
        wait (contact_q.size() == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= wdata;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CENTER_X:      sph_cx  = wdata;
            CFG_CENTER_Y:      sph_cy  = wdata;
            CFG_CENTER_Z:      sph_cz  = wdata;
            CFG_SPHERE_RADIUS: sph_rad = wdata[30:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // offer one particle, with an optional idle gap ahead of it
    task automatic send_particle(t_sic_in it, bit gaps);
        int gap;
        gap = 0;
        if (gaps && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // particle placed near the shell, near the centre, at random, or on the centre
    function automatic t_sic_in random_particle();
        t_sic_in it;
        longint  off[3], rad, prad, base;
        int      ax, mode;
        begin
            rad  = longint'({33'b0, sph_rad});
            prad = ($urandom_range(0, 3) == 0) ? longint'($urandom() & 32'h7FFF_FFFF)
                                               : longint'($urandom_range(0, 32'h0004_0000));
            mode = $urandom_range(0, 9);
            off[0] = 0; off[1] = 0; off[2] = 0;
            if (mode < 6) begin
                ax   = $urandom_range(0, 2);
                base = rad + longint'($urandom_range(0, 2 * 32'h0004_0000)) - 32'h0004_0000;
                off[ax] = $urandom_range(0, 1) ? base : -base;
                off[(ax + 1) % 3] = longint'($urandom_range(0, 32'h0000_8000)) - 32'h4000;
                off[(ax + 2) % 3] = longint'($urandom_range(0, 32'h0000_8000)) - 32'h4000;
            end else if (mode < 8) begin
                for (int i = 0; i < 3; i++) off[i] = longint'($urandom_range(0, 32'h1_0000)) - 32'h8000;
            end
            it.pos_x = 32'(longint'(sph_cx) + off[0]);
            it.pos_y = 32'(longint'(sph_cy) + off[1]);
            it.pos_z = 32'(longint'(sph_cz) + off[2]);
            it.probe_radius = 31'(prad);
            if (mode == 8) begin
                it.pos_x = $urandom(); it.pos_y = $urandom(); it.pos_z = $urandom();
                it.probe_radius = 31'($urandom());
            end
            return it;
        end
    endfunction

    t_row drows[$];

    function automatic t_row item_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic [30:0] r, bit has_exp, t_sic_out exp);
        t_row w;
        w = '{kind: ROW_ITEM, idx: CFG_CENTER_X, wdata: '0, item: '{x, y, z, r},
              has_exp: has_exp, exp: exp};
        return w;
    endfunction

    function automatic t_row cfg_row(t_cfg_idx idx, logic [31:0] wdata);
        t_row w;
        w = '{kind: ROW_CFG, idx: idx, wdata: wdata, item: '0, has_exp: 0, exp: '0};
        return w;
    endfunction

    initial begin
        t_sic_out none;
        none = '0;
        // after reset: centre at origin, radius 1.0
        drows.push_back(item_row(0, 0, 0, 0, 1, '{1, 1, 0, 0, 0, 0}));
        drows.push_back(item_row(32'h1_0000, 0, 0, 0, 1, '{1, 1, 1, 0, 0, 0}));
        drows.push_back(item_row(32'h2_0000, 0, 0, 31'h1_0000, 1,
                                 '{0, 0, 1, 32'hFFFF_0000, 0, 0}));
        // zero distance while touching gives no push
        drows.push_back(item_row(0, 0, 0, 31'h1_0000, 1, '{1, 1, 1, 0, 0, 0}));
        drows.push_back(item_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 31'h7FFF_FFFF, 1, '{0, 0, 0, 0, 0, 0}));
        drows.push_back(item_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 31'h7FFF_FFFF, 1, '{0, 0, 0, 0, 0, 0}));
        drows.push_back(item_row(32'hFFFF_8000, 32'h0000_4000, 32'hFFFF_C000, 31'h8000, 0, none));
        drows.push_back(item_row(0, 32'hFFFE_8000, 0, 31'h1_0000, 0, none));
        drows.push_back(item_row(32'h0000_B505, 32'h0000_B505, 0, 31'h100, 0, none));
        // extreme centre, radius write with bit 31 set is cut to 31 bits
        drows.push_back(cfg_row(CFG_CENTER_X, 32'h8000_0000));
        drows.push_back(cfg_row(CFG_CENTER_Y, 32'h7FFF_FFFF));
        drows.push_back(cfg_row(CFG_CENTER_Z, 32'hFFFF_FFFF));
        drows.push_back(cfg_row(CFG_SPHERE_RADIUS, 32'hFFFF_FFFF));
        drows.push_back(item_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h7FFF_FFFF, 0, none));
        drows.push_back(item_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h0, 0, none));
        drows.push_back(item_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h1, 0, none));
        drows.push_back(item_row(32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000, 0, none));
        // zero radius sphere
        drows.push_back(cfg_row(CFG_SPHERE_RADIUS, 32'h0));
        drows.push_back(item_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h0, 0, none));
        drows.push_back(item_row(32'h8001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h1_0000, 0, none));
        drows.push_back(item_row(32'h8000_0003, 32'h7FFF_FFFC, 32'hFFFF_FFFF, 31'h5, 0, none));
    end

    // stimulus: directed table, then random phases under changing settings
    initial begin
        t_row cur;
        bit   gaps;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (drows[k]) begin
            cur = drows[k];
            if (cur.kind == ROW_CFG) begin
                i_in_valid <= 1'b0;
                write_reg(cur.idx, cur.wdata);
            end else begin
                row_has_exp = cur.has_exp;
                row_exp     = cur.exp;
                send_particle(cur.item, 1);
            end
        end
        row_has_exp = 0;

        for (int p = 0; p < N_PHASES; p++) begin
            i_in_valid <= 1'b0;
            write_reg(CFG_CENTER_X, (p == 1) ? 32'h7FFF_FFFF : $urandom() >> $urandom_range(0, 16));
            write_reg(CFG_CENTER_Y, (p == 1) ? 32'h8000_0000 : $urandom() >> $urandom_range(0, 16));
            write_reg(CFG_CENTER_Z, (p == 2) ? 32'h0 : $urandom());
            case (p)
                0:       write_reg(CFG_SPHERE_RADIUS, 32'h0001_0000);
                1:       write_reg(CFG_SPHERE_RADIUS, 32'h7FFF_FFFF);
                2:       write_reg(CFG_SPHERE_RADIUS, 32'h8000_0000);
                default: write_reg(CFG_SPHERE_RADIUS, $urandom() >> $urandom_range(0, 12));
            endcase
            gaps = (p != 3);        // one phase runs back to back
            for (int k = 0; k < PHASE_ITEMS; k++) send_particle(random_particle(), gaps);
        end
        i_in_valid <= 1'b0;

        wait (contact_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && contact_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
